// ===== rtl/barp_pkg.sv =====
package barp_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE    = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_COUNT = 8'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BLOCK_ZERO = 3'd1,
    ST_COUNT_ZERO = 3'd2,
    ST_END_BEFORE = 3'd3,
    ST_NOT_DIV    = 3'd4
  } status_e;

endpackage

// ===== rtl/barp_front.sv =====
module barp_front #(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [barp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [barp_pkg::CfgW-1:0]         cfg_data_i,
  input  logic [INDEX_BITS-1:0]             range_start_i,
  input  logic [INDEX_BITS-1:0]             range_end_i,
  output barp_pkg::status_e                 status_o,
  output logic [INDEX_BITS-1:0]             total_o,
  output logic [barp_pkg::CfgW-1:0]         block_size_o,
  output logic [barp_pkg::CfgW-1:0]         segment_count_o
);

  logic [barp_pkg::CfgW-1:0] block_size_q, block_size_d;
  logic [barp_pkg::CfgW-1:0] segment_count_q, segment_count_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    block_size_d    = block_size_q;
    segment_count_d = segment_count_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == barp_pkg::CFG_BLOCK_SIZE) block_size_d = cfg_data_i;
      if (cfg_index_i == barp_pkg::CFG_SEGMENT_COUNT) segment_count_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q    <= barp_pkg::CfgW'(1);
      segment_count_q <= barp_pkg::CfgW'(1);
    end else begin
      block_size_q    <= block_size_d;
      segment_count_q <= segment_count_d;
    end
  end

  always_comb begin
    priority if (block_size_q == '0) status_o = barp_pkg::ST_BLOCK_ZERO;
    else if (segment_count_q == '0) status_o = barp_pkg::ST_COUNT_ZERO;
    else if (range_end_i < range_start_i) status_o = barp_pkg::ST_END_BEFORE;
    else status_o = barp_pkg::ST_OK;
  end

  assign total_o         = range_end_i - range_start_i;
  assign block_size_o    = block_size_q;
  assign segment_count_o = segment_count_q;

endmodule

// ===== rtl/barp_fifo.sv =====
module barp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/barp_div.sv =====
module barp_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned VW = 16,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [PW-1:0] payload_i,
  output logic          valid_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o,
  output logic [VW-1:0] divisor_o,
  output logic [PW-1:0] payload_o
);

  logic [VW-1:0] r_q  [DW];
  logic [DW-1:0] qd_q [DW];
  logic [VW-1:0] d_q  [DW];
  logic [PW-1:0] p_q  [DW];
  logic          v_q  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] r_s, d_s;
    logic [DW-1:0] qd_s;
    logic [PW-1:0] p_s;
    logic          v_s;
    logic [VW:0]   rc;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_s  = '0;
      assign qd_s = dividend_i;
      assign d_s  = divisor_i;
      assign p_s  = payload_i;
      assign v_s  = valid_i;
    end else begin : g_next
      assign r_s  = r_q[k-1];
      assign qd_s = qd_q[k-1];
      assign d_s  = d_q[k-1];
      assign p_s  = p_q[k-1];
      assign v_s  = v_q[k-1];
    end

    assign rc = {r_s, qd_s[DW-1]};
    assign ge = rc >= {1'b0, d_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? VW'(rc - {1'b0, d_s}) : rc[VW-1:0];
        qd_q[k] <= {qd_s[DW-2:0], ge};
        d_q[k]  <= d_s;
        p_q[k]  <= p_s;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s;
      end
    end
  end

  assign valid_o     = v_q[DW-1];
  assign quotient_o  = qd_q[DW-1];
  assign remainder_o = r_q[DW-1];
  assign divisor_o   = d_q[DW-1];
  assign payload_o   = p_q[DW-1];

endmodule

// ===== rtl/barp_back.sv =====
module barp_back #(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          pop_o,
  input  barp_pkg::status_e             status_i,
  input  logic [INDEX_BITS-1:0]         range_start_i,
  input  logic [INDEX_BITS-1:0]         range_end_i,
  input  logic [INDEX_BITS-1:0]         total_i,
  input  logic [barp_pkg::CfgW-1:0]     block_size_i,
  input  logic [barp_pkg::CfgW-1:0]     segment_count_i,
  input  logic [barp_pkg::CfgW-1:0]     segment_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [INDEX_BITS-1:0]         segment_start_o,
  output logic [INDEX_BITS-1:0]         segment_end_o,
  output logic [INDEX_BITS-1:0]         segment_size_o,
  output logic [2:0]                    status_o
);

  localparam int unsigned W  = INDEX_BITS;
  localparam int unsigned CW = barp_pkg::CfgW;
  localparam int unsigned P1 = 3 + 2 * W + 2 * CW;
  localparam int unsigned P2 = 3 + 2 * W + 2 * CW;

  logic en;
  assign en    = !(out_valid_o && out_stall_i);
  assign pop_o = en;

  logic          v1;
  logic [W-1:0]  q1;
  logic [CW-1:0] r1, bs1;
  logic [P1-1:0] p1;

  barp_div #(.DW(W), .VW(CW), .PW(P1)) u_div_blocks (
    .clk_i, .rst_ni, .en_i(en), .valid_i,
    .dividend_i (total_i),
    .divisor_i  (block_size_i),
    .payload_i  ({status_i, range_start_i, range_end_i, segment_count_i, segment_index_i}),
    .valid_o    (v1),
    .quotient_o (q1),
    .remainder_o(r1),
    .divisor_o  (bs1),
    .payload_o  (p1)
  );

  logic [2:0]    st1, st1f;
  logic [W-1:0]  rs1, re1;
  logic [CW-1:0] cnt1, idx1;
  assign {st1, rs1, re1, cnt1, idx1} = p1;
  assign st1f = (st1 == barp_pkg::ST_OK && r1 != '0) ? barp_pkg::ST_NOT_DIV : st1;

  logic          v2;
  logic [W-1:0]  q2;
  logic [CW-1:0] r2, cnt2;
  logic [P2-1:0] p2;

  barp_div #(.DW(W), .VW(CW), .PW(P2)) u_div_segs (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i    (v1),
    .dividend_i (q1),
    .divisor_i  (cnt1),
    .payload_i  ({st1f, rs1, re1, bs1, idx1}),
    .valid_o    (v2),
    .quotient_o (q2),
    .remainder_o(r2),
    .divisor_o  (cnt2),
    .payload_o  (p2)
  );

  logic [2:0]    st2;
  logic [W-1:0]  rs2, re2;
  logic [CW-1:0] bs2, idx2;
  logic          lt2;
  assign {st2, rs2, re2, bs2, idx2} = p2;
  assign lt2 = idx2 < r2;

  logic          m1_v_q, m2_v_q;
  logic [W-1:0]  m1_off_q, m1_len_q, m1_rs_q, m1_re_q;
  logic [CW-1:0] m1_bs_q;
  logic [2:0]    m1_st_q, m2_st_q;
  logic          m1_ovr_q, m2_ovr_q;
  logic [W-1:0]  m2_offb_q, m2_lenb_q, m2_rs_q, m2_re_q;
  logic [W-1:0]  s3;

  assign s3 = m2_rs_q + m2_offb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_off_q  <= W'(q2 * W'(idx2)) + W'(lt2 ? idx2 : r2);
      m1_len_q  <= q2 + W'(lt2);
      m1_rs_q   <= rs2;
      m1_re_q   <= re2;
      m1_bs_q   <= bs2;
      m1_st_q   <= st2;
      m1_ovr_q  <= idx2 >= cnt2;
      m2_offb_q <= W'(m1_off_q * W'(m1_bs_q));
      m2_lenb_q <= W'(m1_len_q * W'(m1_bs_q));
      m2_rs_q   <= m1_rs_q;
      m2_re_q   <= m1_re_q;
      m2_st_q   <= m1_st_q;
      m2_ovr_q  <= m1_ovr_q;
      if (m2_st_q != barp_pkg::ST_OK) begin
        segment_start_o <= '0;
        segment_end_o   <= '0;
        segment_size_o  <= '0;
      end else if (m2_ovr_q) begin
        segment_start_o <= m2_re_q;
        segment_end_o   <= m2_re_q;
        segment_size_o  <= '0;
      end else begin
        segment_start_o <= s3;
        segment_end_o   <= s3 + m2_lenb_q;
        segment_size_o  <= m2_lenb_q;
      end
      status_o <= m2_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q      <= 1'b0;
      m2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      m1_v_q      <= v2;
      m2_v_q      <= m1_v_q;
      out_valid_o <= m2_v_q;
    end
  end

endmodule

// ===== rtl/block_aligned_range_partition_core.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_stall_o  | range_start_i, range_end_i, segment_index_i
// out     | output    | out_valid_o/out_stall_i| segment_start_o, segment_end_o, segment_size_o, status_o
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
// One transaction per cycle sustained while out_stall_i is low; each result passes through
// the queue slot and the two bit-per-stage restoring divider pipelines
// (blocks, then per-segment quotient) plus two multiply stages and the output register.
// Reset clears valid state and loads block_size and segment_count with 1; cfg_ready_o is 1.
// An output stall freezes the back pipeline; the 2-entry queue absorbs input until full.
module block_aligned_range_partition_core #(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [barp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [barp_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [INDEX_BITS-1:0]         range_start_i,
  input  logic [INDEX_BITS-1:0]         range_end_i,
  input  logic [barp_pkg::CfgW-1:0]     segment_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [INDEX_BITS-1:0]         segment_start_o,
  output logic [INDEX_BITS-1:0]         segment_end_o,
  output logic [INDEX_BITS-1:0]         segment_size_o,
  output logic [2:0]                    status_o
);

  localparam int unsigned W  = INDEX_BITS;
  localparam int unsigned CW = barp_pkg::CfgW;
  localparam int unsigned QW = 3 + 3 * W + 3 * CW;

  barp_pkg::status_e f_st;
  logic [W-1:0]      f_total;
  logic [CW-1:0]     f_bs, f_cnt;

  barp_front #(.INDEX_BITS(W)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .range_start_i, .range_end_i,
    .status_o       (f_st),
    .total_o        (f_total),
    .block_size_o   (f_bs),
    .segment_count_o(f_cnt)
  );

  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_data;

  barp_fifo #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i (in_valid_i),
    .data_i ({f_st, range_start_i, range_end_i, f_total, f_bs, f_cnt, segment_index_i}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_data)
  );

  assign in_stall_o = q_full;

  logic [2:0]    b_st;
  logic [W-1:0]  b_rs, b_re, b_total;
  logic [CW-1:0] b_bs, b_cnt, b_idx;
  assign {b_st, b_rs, b_re, b_total, b_bs, b_cnt, b_idx} = q_data;

  barp_back #(.INDEX_BITS(W)) u_back (
    .clk_i, .rst_ni,
    .valid_i        (!q_empty),
    .pop_o          (q_pop),
    .status_i       (barp_pkg::status_e'(b_st)),
    .range_start_i  (b_rs),
    .range_end_i    (b_re),
    .total_i        (b_total),
    .block_size_i   (b_bs),
    .segment_count_i(b_cnt),
    .segment_index_i(b_idx),
    .out_valid_o, .out_stall_i,
    .segment_start_o, .segment_end_o, .segment_size_o, .status_o
  );

endmodule

// ===== verif/barp_checker.sv =====
`timescale 1ns / 1ps

module barp_checker #(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [barp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [barp_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [INDEX_BITS-1:0]      range_start_i,
  input  logic [INDEX_BITS-1:0]      range_end_i,
  input  logic [barp_pkg::CfgW-1:0]  segment_index_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [INDEX_BITS-1:0]      segment_start_i,
  input  logic [INDEX_BITS-1:0]      segment_end_i,
  input  logic [INDEX_BITS-1:0]      segment_size_i,
  input  logic [2:0]                 status_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         seg_done_o
);

  typedef struct packed {
    logic [INDEX_BITS-1:0] seg_start;
    logic [INDEX_BITS-1:0] seg_end;
    logic [INDEX_BITS-1:0] seg_size;
    barp_pkg::status_e     status;
  } bounds_t;

  bounds_t         bounds_q[$];
  logic [15:0]     blk_size;
  logic [15:0]     seg_count;

  function automatic bounds_t partition_bounds(logic [INDEX_BITS-1:0] rs,
                                               logic [INDEX_BITS-1:0] re,
                                               logic [15:0] idx);
    bounds_t     b;
    logic [63:0] total, blocks, quot, rem, off, len, s;
    b = '0;
    b.status = barp_pkg::ST_OK;
    if (blk_size == 0) b.status = barp_pkg::ST_BLOCK_ZERO;
    else if (seg_count == 0) b.status = barp_pkg::ST_COUNT_ZERO;
    else if (re < rs) b.status = barp_pkg::ST_END_BEFORE;
    else begin
      total = 64'(re) - 64'(rs);
      if (total % blk_size != 0) b.status = barp_pkg::ST_NOT_DIV;
      else if (idx >= seg_count) begin
        b.seg_start = re;
        b.seg_end = re;
      end else begin
        blocks = total / blk_size;
        quot = blocks / seg_count;
        rem = blocks - quot * seg_count;
        if (idx < rem) begin
          len = quot + 1;
          off = len * idx;
        end else begin
          len = quot;
          off = rem * (quot + 1) + (idx - rem) * quot;
        end
        s = rs + off * blk_size;
        b.seg_start = s[INDEX_BITS-1:0];
        b.seg_end = INDEX_BITS'(s + len * blk_size);
        b.seg_size = INDEX_BITS'(len * blk_size);
      end
    end
    return b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bounds_t e;
    if (!rst_ni) begin
      blk_size <= 16'd1;
      seg_count <= 16'd1;
      fail_count_o <= 0;
      seg_done_o <= 0;
      bounds_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == barp_pkg::CFG_BLOCK_SIZE) blk_size <= cfg_data_i;
        else if (cfg_index_i == barp_pkg::CFG_SEGMENT_COUNT) seg_count <= cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        seg_done_o <= seg_done_o + 1;
        if (bounds_q.size() == 0) begin
          $display("%0t: unexpected transaction start=%h", $time, segment_start_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = bounds_q.pop_front();
          if (segment_start_i !== e.seg_start || segment_end_i !== e.seg_end ||
              segment_size_i !== e.seg_size || status_i !== e.status) begin
            $display("%0t: mismatch exp start=%h end=%h size=%h st=%0d",
                     $time, e.seg_start, e.seg_end, e.seg_size, e.status);
            $display("%0t:          act start=%h end=%h size=%h st=%0d",
                     $time, segment_start_i, segment_end_i, segment_size_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        bounds_q.push_back(partition_bounds(range_start_i, range_end_i, segment_index_i));
    end
  end

  assign pending_o = bounds_q.size();
endmodule

// ===== verif/tb_block_aligned_range_partition_core.sv =====
`timescale 1ns / 1ps

module tb_block_aligned_range_partition_core;

  localparam int unsigned IW = 31;
  localparam int unsigned LATENCY = 2 * IW + 4;
  localparam int CYCLE_LIMIT = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [barp_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [barp_pkg::CfgW-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [IW-1:0] range_start_i = '0;
  logic [IW-1:0] range_end_i = '0;
  logic [barp_pkg::CfgW-1:0] segment_index_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [IW-1:0] segment_start_o, segment_end_o, segment_size_o;
  logic [2:0]    status_o;
  int            fail_count, pending, seg_done, cycles;
  int            stall_mode;  // 0 random, 1 long hold, 2 none
  int            reqs_sent;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  block_aligned_range_partition_core #(.INDEX_BITS(IW)) dut (.*);

  barp_checker #(.INDEX_BITS(IW)) u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .range_start_i, .range_end_i, .segment_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .segment_start_i(segment_start_o),
    .segment_end_i(segment_end_o), .segment_size_i(segment_size_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending), .seg_done_o(seg_done));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL block_aligned_range_partition_core");
      $finish;
    end
  end

  // receiver side stall
  initial begin
    int n;
    stall_mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_mode == 1) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        stall_mode = 0;
      end else if (stall_mode == 0 && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [barp_pkg::CfgIdxW-1:0] idx, logic [barp_pkg::CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_all();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_range(logic [IW-1:0] rs, logic [IW-1:0] re, logic [15:0] idx,
                            bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    range_start_i <= rs;
    range_end_i <= re;
    segment_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    reqs_sent++;
  endtask

  task automatic set_config(logic [15:0] bs, logic [15:0] cnt);
    in_valid_i <= 1'b0;
    drain_all();
    write_reg(barp_pkg::CFG_BLOCK_SIZE, bs);
    write_reg(barp_pkg::CFG_SEGMENT_COUNT, cnt);
  endtask

  // mostly well-formed requests: length a multiple of the block size, with some random or off-by-one ranges
  task automatic send_aligned(logic [15:0] bs, logic [15:0] cnt, bit gaps);
    logic [63:0] blocks, rs, len;
    logic [15:0] idx;
    blocks = (bs == 0) ? 0 : $urandom_range(0, 3 * (cnt + 1)) ;
    if ($urandom_range(0, 7) == 0 && bs != 0) blocks = $urandom_range(0, 32'h7fffffff) / bs;
    len = blocks * bs;
    rs = {$urandom} % (64'h8000_0000 - len);
    if ($urandom_range(0, 3) == 0) rs = 64'h7fff_ffff - len + 1 - (len == 0);
    idx = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, cnt));
    case ($urandom_range(0, 9))
      0: send_range(IW'($urandom), IW'($urandom), 16'($urandom), gaps);
      1: send_range(IW'(rs), IW'(rs + len + 1), idx, gaps);
      default: send_range(IW'(rs), IW'(rs + len), idx, gaps);
    endcase
  endtask

  initial begin
    logic [15:0] bs_list[6];
    logic [15:0] cnt_list[6];
    bs_list = '{16'd1, 16'd3, 16'd64, 16'd1000, 16'hffff, 16'd7};
    cnt_list = '{16'd1, 16'd5, 16'hffff, 16'd7, 16'd3, 16'd16};
    cycles = 0;
    reqs_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: blocks of 1, one segment
    send_range('0, '0, 16'd0, 0);
    send_range('0, '1, 16'd0, 0);
    send_range('1, '1, 16'hffff, 0);
    send_range(IW'(10), IW'(5), 16'd0, 0);
    set_config(16'd4, 16'd3);
    send_range(IW'(0), IW'(40), 16'd0, 0);
    send_range(IW'(0), IW'(40), 16'd1, 0);
    send_range(IW'(0), IW'(40), 16'd2, 0);
    send_range(IW'(0), IW'(40), 16'd3, 0);
    send_range(IW'(0), IW'(41), 16'd0, 0);
    send_range(IW'(100), IW'(99), 16'd0, 0);
    send_range(IW'(8), IW'(8), 16'd2, 0);
    set_config(16'd0, 16'd0);
    send_range(IW'(0), IW'(41), 16'd0, 0);
    set_config(16'd5, 16'd0);
    send_range(IW'(9), IW'(1), 16'd0, 0);
    set_config(16'hffff, 16'hffff);
    send_range('0, IW'(32'h7ffe_0001), 16'hfffe, 0);
    send_range('0, IW'(32'h7ffe_0001), 16'hffff, 0);
    send_range('1, '0, 16'h5555, 0);
    send_range(IW'(32'h2aaa_aaaa), IW'(32'h5555_5555), 16'haaaa, 0);

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      set_config(bs_list[ph], cnt_list[ph]);
      if (ph == 2) begin
        stall_mode = 1;
        for (int i = 0; i < 40; i++) send_aligned(bs_list[ph], cnt_list[ph], 0);
      end
      if (ph == 5) stall_mode = 2;
      for (int i = 0; i < 100; i++) send_aligned(bs_list[ph], cnt_list[ph], ph != 5);
      if (ph == 3) begin
        in_valid_i <= 1'b0;
        drain_all();
        for (int i = 0; i < 10; i++) send_aligned(bs_list[ph], cnt_list[ph], 1);
      end
    end
    in_valid_i <= 1'b0;
    drain_all();

    $display("%0d requests over six settings incl. error codes, out-of-range segments,",
             reqs_sent);
    $display("empty ranges, a long output hold and a full drain; %0d results checked",
             seg_done);
    if (fail_count == 0 && pending == 0)
      $display("PASS block_aligned_range_partition_core");
    else
      $display("FAIL block_aligned_range_partition_core");
    $finish;
  end
endmodule
